[rtl/core/rmte_pkg.sv]
// ----------------------------------------------------------------------------
// rmte_pkg
// Shared types and constants for the modulus, totient and exponent block.
// ----------------------------------------------------------------------------
package rmte_pkg;

    localparam int FACTOR_WIDTH_DEF = 16;
    localparam int PROD_W           = 32;
    localparam int EXP_W            = 5;
    localparam int CAND_W           = EXP_W + 1;
    localparam int EXP_MAX          = 31;
    localparam int CAND_FIRST       = 2;
    localparam int DIV_STEPS        = PROD_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CAND,
        ST_CHECK,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic load_prod;
        logic load_gcd;
        logic next_cand;
        logic div_start;
        logic div_step;
        logic div_end;
        logic set_found;
    } t_dp_cmd;

    typedef struct packed {
        logic cand_stop;
        logic b_zero;
        logic a_one;
        logic div_last;
    } t_dp_stat;

endpackage

[rtl/core/rsa_modulus_totient_exponent.sv]
// ----------------------------------------------------------------------------
// rsa_modulus_totient_exponent
// RSA modulus, totient and smallest coprime public exponent from two factors.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_factor_p and i_factor_q and pulse start while busy is low; the
//   item is taken at that edge and busy rises on the next cycle.
//   When done, o_modulus, o_totient, o_public_exponent and o_exponent_found
//   are shown for one cycle with o_valid high. The receiver cannot stall;
//   it must take the item in that cycle. Outputs hold until the next item.
//   Sequence: capture, products and result, plus per candidate ST_CAND and
//   ST_CHECK (only ST_CAND for the candidate that ends a search without a
//   find) and, per Euclid step, the bit-serial remainder unit (one bit of
//   a 32-bit dividend per cycle) and ST_DIV_END. The candidate search and
//   that remainder unit do most of the work: at most 30 candidates, 2 to
//   31, per item. One item at a time: busy stays high until o_valid.
//   Reset (synchronous, active low) returns the controller to idle and
//   drops any item in progress; no result comes from it.
// ----------------------------------------------------------------------------
module rsa_modulus_totient_exponent #(
    parameter int FACTOR_WIDTH = rmte_pkg::FACTOR_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [FACTOR_WIDTH-1:0]       i_factor_p,
    input  logic [FACTOR_WIDTH-1:0]       i_factor_q,
    output logic                          o_valid,
    output logic [rmte_pkg::PROD_W-1:0]   o_modulus,
    output logic [rmte_pkg::PROD_W-1:0]   o_totient,
    output logic [rmte_pkg::EXP_W-1:0]    o_public_exponent,
    output logic                          o_exponent_found
);
    import rmte_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rmte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    rmte_dp #(
        .FACTOR_WIDTH (FACTOR_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_factor_p        (i_factor_p),
        .i_factor_q        (i_factor_q),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_modulus         (o_modulus),
        .o_totient         (o_totient),
        .o_public_exponent (o_public_exponent),
        .o_exponent_found  (o_exponent_found)
    );

endmodule

[rtl/core/rmte_dp.sv]
// ----------------------------------------------------------------------------
// rmte_dp
// Datapath: factor capture, products, candidate counter and serial remainder.
// ----------------------------------------------------------------------------
module rmte_dp #(
    parameter int FACTOR_WIDTH = rmte_pkg::FACTOR_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic [FACTOR_WIDTH-1:0]       i_factor_p,
    input  logic [FACTOR_WIDTH-1:0]       i_factor_q,
    input  rmte_pkg::t_dp_cmd             i_cmd,
    output rmte_pkg::t_dp_stat            o_stat,
    output logic [rmte_pkg::PROD_W-1:0]   o_modulus,
    output logic [rmte_pkg::PROD_W-1:0]   o_totient,
    output logic [rmte_pkg::EXP_W-1:0]    o_public_exponent,
    output logic                          o_exponent_found
);
    import rmte_pkg::*;

    logic [FACTOR_WIDTH-1:0] r_p, r_q;
    logic [FACTOR_WIDTH-1:0] n_pm, n_qm;
    logic [PROD_W-1:0]       r_mod, r_tot;
    logic [CAND_W-1:0]       r_cand;
    logic [EXP_W-1:0]        r_exp;
    logic                    r_found;
    logic [PROD_W-1:0]       r_a, r_b, r_rem, r_dvd;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [PROD_W:0]         n_rem_sh;
    logic                    n_ge;

    // Minus-one terms saturate at zero
    assign n_pm = (r_p == '0) ? '0 : r_p - FACTOR_WIDTH'(1);
    assign n_qm = (r_q == '0) ? '0 : r_q - FACTOR_WIDTH'(1);

    assign n_rem_sh = {r_rem, r_dvd[PROD_W-1]};
    assign n_ge     = n_rem_sh >= {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_p <= i_factor_p;
            r_q <= i_factor_q;
        end
        if (i_cmd.load_prod) begin
            r_mod   <= PROD_W'(r_p) * PROD_W'(r_q);
            r_tot   <= PROD_W'(n_pm) * PROD_W'(n_qm);
            r_cand  <= CAND_W'(CAND_FIRST);
            r_exp   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.next_cand) begin
            r_cand <= r_cand + CAND_W'(1);
        end
        if (i_cmd.set_found) begin
            r_exp   <= r_cand[EXP_W-1:0];
            r_found <= 1'b1;
        end
        if (i_cmd.load_gcd) begin
            r_a <= PROD_W'(r_cand);
            r_b <= r_tot;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= r_a;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            // restoring step: shift one dividend bit in, subtract when it fits
            r_rem <= n_ge ? PROD_W'(n_rem_sh - {1'b0, r_b}) : n_rem_sh[PROD_W-1:0];
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.div_end) begin
            r_a <= r_b;
            r_b <= r_rem;
        end
    end

    assign o_stat.cand_stop = (r_cand > CAND_W'(EXP_MAX)) || (PROD_W'(r_cand) >= r_tot);
    assign o_stat.b_zero    = (r_b == '0);
    assign o_stat.a_one     = (r_a == PROD_W'(1));
    assign o_stat.div_last  = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    assign o_modulus         = r_mod;
    assign o_totient         = r_tot;
    assign o_public_exponent = r_exp;
    assign o_exponent_found  = r_found;

endmodule

[rtl/core/rmte_ctrl.sv]
// ----------------------------------------------------------------------------
// rmte_ctrl
// Controller: sequences products, candidate search and Euclid steps.
// ----------------------------------------------------------------------------
module rmte_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rmte_pkg::t_dp_stat   i_stat,
    output rmte_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);
    import rmte_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.load_prod = 1'b1;
                n_state         = ST_CAND;
            end
            ST_CAND: begin
                if (i_stat.cand_stop) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.load_gcd = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.b_zero) begin
                    if (i_stat.a_one) begin
                        o_cmd.set_found = 1'b1;
                        n_state         = ST_DONE;
                    end else begin
                        o_cmd.next_cand = 1'b1;
                        n_state         = ST_CAND;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                // advance Euclid: (a, b) <= (b, a mod b)
                o_cmd.div_end = 1'b1;
                n_state       = ST_CHECK;
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/rmte_checker.sv]
// ----------------------------------------------------------------------------
// rmte_checker
// Port-level checks on the command handshake and the result item.
// ----------------------------------------------------------------------------
module rmte_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [rmte_pkg::PROD_W-1:0]   o_totient,
    input logic [rmte_pkg::EXP_W-1:0]    o_public_exponent,
    input logic                          o_exponent_found
);
    import rmte_pkg::*;

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item taken but busy did not rise");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_exponent_found |->
            (o_public_exponent >= EXP_W'(CAND_FIRST)) &&
            (PROD_W'(o_public_exponent) < o_totient))
        else $error("found exponent out of range");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_exponent_found |->
            (o_public_exponent == '0) && (o_totient < PROD_W'(3)))
        else $error("no exponent reported for a totient that has one");

endmodule

bind rsa_modulus_totient_exponent rmte_checker u_rmte_checker (.*);

[sim/rsa_modulus_totient_exponent_test.sv]
// ----------------------------------------------------------------------------
// rsa_modulus_totient_exponent_test
// Self-checking bench for the modulus, totient and public exponent block.
// Factor pairs go in through the start/busy handshake with random gaps. Each
// strobed result is checked field by field against a behavioral model of the
// key derivation. The pairs cover zero and unit factors, small totients with
// no exponent, smooth totients that push the exponent search far, and full
// range random values.
// ----------------------------------------------------------------------------
module rsa_modulus_totient_exponent_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmte_pkg::*;

    localparam int FW           = FACTOR_WIDTH_DEF;
    localparam int GAP_MAX      = 6;
    localparam int RANDOM_PAIRS = 76;
    localparam int CYCLE_LIMIT  = 130 * (16384 + GAP_MAX + 2) * 3;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [FW-1:0] p;
        logic [FW-1:0] q;
    } factor_pair_t;

    typedef struct packed {
        logic [PROD_W-1:0] modulus;
        logic [PROD_W-1:0] totient;
        logic [EXP_W-1:0]  exponent;
        logic              found;
    } rsa_key_t;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic [FW-1:0]     i_factor_p = '0;
    logic [FW-1:0]     i_factor_q = '0;
    logic              busy;
    logic              o_valid;
    logic [PROD_W-1:0] o_modulus;
    logic [PROD_W-1:0] o_totient;
    logic [EXP_W-1:0]  o_public_exponent;
    logic              o_exponent_found;

    factor_pair_t factor_pairs[$];
    rsa_key_t     keys_due[$];

    int gap_left     = 0;
    bit no_gaps      = 1'b0;
    int pairs_sent   = 0;
    int keys_checked = 0;
    int keys_without = 0;
    int top_exponent = 0;
    int mismatches   = 0;
    int cycle_cnt    = 0;

    rsa_modulus_totient_exponent #(
        .FACTOR_WIDTH(FW)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_factor_p       (i_factor_p),
        .i_factor_q       (i_factor_q),
        .o_valid          (o_valid),
        .o_modulus        (o_modulus),
        .o_totient        (o_totient),
        .o_public_exponent(o_public_exponent),
        .o_exponent_found (o_exponent_found)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [PROD_W-1:0] euclid_gcd(input logic [PROD_W-1:0] a,
                                                     input logic [PROD_W-1:0] b);
        logic [PROD_W-1:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic rsa_key_t derive_key(input factor_pair_t f);
        rsa_key_t          k;
        logic [PROD_W-1:0] pw;
        logic [PROD_W-1:0] qw;
        logic [PROD_W-1:0] pm;
        logic [PROD_W-1:0] qm;
        logic [PROD_W-1:0] cand;
        pw = PROD_W'(f.p);
        qw = PROD_W'(f.q);
        // a zero factor gives a zero term, not a wrapped one
        pm = (pw == 0) ? '0 : pw - 1;
        qm = (qw == 0) ? '0 : qw - 1;
        k.modulus  = pw * qw;
        k.totient  = pm * qm;
        k.exponent = '0;
        k.found    = 1'b0;
        for (cand = CAND_FIRST; cand <= EXP_MAX && cand < k.totient && !k.found;
             cand++) begin
            if (euclid_gcd(cand, k.totient) == 1) begin
                k.exponent = cand[EXP_W-1:0];
                k.found    = 1'b1;
            end
        end
        return k;
    endfunction

    task automatic queue_pair(input int p, input int q);
        factor_pair_t f;
        f.p = p[FW-1:0];
        f.q = q[FW-1:0];
        factor_pairs.push_back(f);
    endtask

    // Driver: present one pair at a time, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_factor_p <= '0;
            i_factor_q <= '0;
            gap_left   = 0;
        end else begin
            if (start && !busy) begin
                factor_pair_t taken;
                taken.p = i_factor_p;
                taken.q = i_factor_q;
                keys_due.push_back(derive_key(taken));
                pairs_sent++;
                if (pairs_sent % 16 == 0) begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                gap_left = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    start <= 1'b0;
                    // count the gap only once the block is free again
                    if (!busy) begin
                        gap_left--;
                    end
                end else if (factor_pairs.size() != 0) begin
                    factor_pair_t nxt;
                    nxt = factor_pairs.pop_front();
                    start      <= 1'b1;
                    i_factor_p <= nxt.p;
                    i_factor_q <= nxt.q;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest pending key
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (keys_due.size() == 0) begin
                $error("result with no item pending: modulus %0d totient %0d",
                       o_modulus, o_totient);
                mismatches++;
            end else begin
                rsa_key_t want;
                want = keys_due.pop_front();
                keys_checked++;
                if (!want.found) begin
                    keys_without++;
                end else if (int'(want.exponent) > top_exponent) begin
                    top_exponent = int'(want.exponent);
                end
                if (o_modulus !== want.modulus) begin
                    $error("modulus: expected %0d, got %0d", want.modulus, o_modulus);
                    mismatches++;
                end
                if (o_totient !== want.totient) begin
                    $error("totient: expected %0d, got %0d", want.totient, o_totient);
                    mismatches++;
                end
                if (o_public_exponent !== want.exponent) begin
                    $error("public_exponent: expected %0d, got %0d",
                           want.exponent, o_public_exponent);
                    mismatches++;
                end
                if (o_exponent_found !== want.found) begin
                    $error("exponent_found: expected %0d, got %0d",
                           want.found, o_exponent_found);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        factor_pair_t f;
        int           mode;
        int           n;
        // zero and unit factors, totient too small for an exponent
        queue_pair(0, 0);
        queue_pair(0, 65535);
        queue_pair(65535, 0);
        queue_pair(0, 5);
        queue_pair(1, 1);
        queue_pair(1, 65535);
        queue_pair(65535, 1);
        queue_pair(2, 2);
        queue_pair(2, 3);
        queue_pair(3, 2);
        // smallest totients that do have an exponent
        queue_pair(2, 4);
        queue_pair(4, 2);
        queue_pair(3, 3);
        queue_pair(2, 5);
        queue_pair(3, 4);
        queue_pair(6, 7);
        // smooth totients drive the search to 23 and 29
        queue_pair(2311, 4200);
        queue_pair(30031, 7430);
        queue_pair(7430, 30031);
        // full range and alternating bit patterns
        queue_pair(65535, 65535);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'h8000, 16'h7FFF);
        queue_pair(16'h7FFF, 16'h8000);
        for (n = 0; n < RANDOM_PAIRS; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                f.p = FW'($urandom);
                f.q = FW'($urandom);
            end else if (mode < 7) begin
                f.p = FW'($urandom_range(0, 12));
                f.q = FW'($urandom_range(0, 12));
            end else begin
                // totient divisible by every prime up to 19
                f.p = FW'(1 + 2310 * $urandom_range(0, 28));
                f.q = FW'(1 + 4199 * $urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) begin
                    f = {f.q, f.p};
                end
            end
            factor_pairs.push_back(f);
        end

        while (factor_pairs.size() != 0 || start || keys_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d factor pairs, checked %0d keys in %0d cycles.",
                 pairs_sent, keys_checked, cycle_cnt);
        $display("Keys without exponent: %0d, largest exponent: %0d.",
                 keys_without, top_exponent);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/rmte_pkg.sv
rtl/core/rmte_dp.sv
rtl/core/rmte_ctrl.sv
rtl/core/rsa_modulus_totient_exponent.sv
rtl/core/rmte_checker.sv
sim/rsa_modulus_totient_exponent_test.sv
